FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the line editor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TGLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define TGLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/tgle_pkg.sv
// ----------------------------------------------------------------------------
// tgle_pkg
// Types, codes and constants shared by the text grid line editor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tgle_pkg;

  localparam int ROWS_DEF   = 16;
  localparam int COLS_DEF   = 32;
  localparam int CHAR_W     = 7;
  localparam int ROW_PORT_W = 4;
  localparam int COL_PORT_W = 5;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_KEY   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam logic [7:0] KEY_ESC  = 8'd27;
  localparam logic [7:0] KEY_BS   = 8'd8;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd127;

  typedef struct packed {
    logic latch;
    logic clr;
    logic sweep;
    logic exec;
    logic col_inc;
    logic resp;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic need_scan;
    logic col_last;
    logic cell_zero;
    logic sweep_done;
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tgle_datapath.sv
// ----------------------------------------------------------------------------
// tgle_datapath
// Grid memory, cursor, flags, input latch and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tgle_datapath #(
  parameter int ROWS = tgle_pkg::ROWS_DEF,
  parameter int COLS = tgle_pkg::COLS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire tgle_pkg::cmd_t                      cmd,
  output tgle_pkg::status_t                        sts,
  input  wire logic [1:0]                          in_op,
  input  wire logic [7:0]                          in_data_byte,
  input  wire logic [tgle_pkg::ROW_PORT_W-1:0]     in_read_row,
  input  wire logic [tgle_pkg::COL_PORT_W-1:0]     in_read_col,
  output logic [tgle_pkg::CHAR_W-1:0]              out_cell_char,
  output logic [tgle_pkg::ROW_PORT_W-1:0]          out_cur_row,
  output logic [tgle_pkg::COL_PORT_W-1:0]          out_cur_col,
  output logic                                     out_modified,
  output logic                                     out_cut_short,
  output logic                                     out_save_request
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS * (1 << CW);
  localparam int RPW   = tgle_pkg::ROW_PORT_W;
  localparam int CPW   = tgle_pkg::COL_PORT_W;
  localparam int CHW   = tgle_pkg::CHAR_W;

  tgle_pkg::op_t        op_r;
  logic [7:0]           byte_r;
  logic [RPW-1:0]       rrow_r;
  logic [CPW-1:0]       rcol_r;

  logic [RW-1:0]        cur_row_r, cur_row_nxt;
  logic [CW-1:0]        cur_col_r, cur_col_nxt;
  logic                 dirty_r, dirty_nxt;
  logic                 trunc_r, trunc_nxt;
  logic                 stop_r, stop_nxt;
  logic [AW-1:0]        sweep_r, sweep_nxt;

  logic [CHW-1:0]       mem [DEPTH];
  logic [CHW-1:0]       rdata_r;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [CHW-1:0]       wdata;
  logic [AW-1:0]        raddr;

  logic [CHW-1:0]       out_char_r;
  logic [RW-1:0]        out_row_r;
  logic [CW-1:0]        out_col_r;
  logic                 out_mod_r;
  logic                 out_cut_r;
  logic                 out_save_r;

  logic                 rd_ok;
  logic                 col_last;
  logic                 row_last;
  logic                 printable;
  logic [AW-1:0]        cur_addr;
  logic [AW-1:0]        rd_addr;

  assign rd_ok     = (int'(rrow_r) < ROWS) && (int'(rcol_r) < COLS);
  assign col_last  = cur_col_r == CW'(COLS - 1);
  assign row_last  = cur_row_r == RW'(ROWS - 1);
  assign printable = (byte_r >= tgle_pkg::PRINT_LO) && (byte_r < tgle_pkg::PRINT_HI);
  assign cur_addr  = {cur_row_r, cur_col_r};
  assign rd_addr   = {RW'(rrow_r), CW'(rcol_r)};
  assign raddr     = (op_r == tgle_pkg::OP_READ) ? rd_addr : cur_addr;

  assign sts.op         = op_r;
  assign sts.need_scan  = (op_r == tgle_pkg::OP_KEY) && (byte_r == tgle_pkg::KEY_BS) &&
                          (cur_col_r == '0) && (cur_row_r != '0);
  assign sts.col_last   = col_last;
  assign sts.cell_zero  = rdata_r == '0;
  assign sts.sweep_done = sweep_r == AW'(DEPTH - 1);

  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    dirty_nxt   = dirty_r;
    trunc_nxt   = trunc_r;
    stop_nxt    = stop_r;
    sweep_nxt   = sweep_r;
    we          = 1'b0;
    waddr       = cur_addr;
    wdata       = '0;
    if (cmd.clr) begin
      cur_row_nxt = '0;
      cur_col_nxt = '0;
      dirty_nxt   = 1'b0;
      trunc_nxt   = 1'b0;
      stop_nxt    = 1'b0;
      sweep_nxt   = '0;
    end else if (cmd.sweep) begin
      we        = 1'b1;
      waddr     = sweep_r;
      sweep_nxt = sweep_r + AW'(1);
    end else if (cmd.col_inc) begin
      cur_col_nxt = cur_col_r + CW'(1);
    end else if (cmd.exec) begin
      case (op_r)
        tgle_pkg::OP_LOAD: begin
          if (!stop_r && (byte_r != tgle_pkg::CH_CR)) begin
            if (byte_r == tgle_pkg::CH_LF) begin
              if (row_last) begin
                trunc_nxt = 1'b1;
                stop_nxt  = 1'b1;
              end else begin
                cur_row_nxt = cur_row_r + RW'(1);
                cur_col_nxt = '0;
              end
            end else if (printable) begin
              if (col_last) begin
                trunc_nxt = 1'b1;
              end else begin
                we          = 1'b1;
                wdata       = byte_r[CHW-1:0];
                cur_col_nxt = cur_col_r + CW'(1);
              end
            end
          end
        end
        tgle_pkg::OP_KEY: begin
          if (byte_r == tgle_pkg::KEY_BS) begin
            if (cur_col_r != '0) begin
              cur_col_nxt = cur_col_r - CW'(1);
              we          = 1'b1;
              waddr       = {cur_row_r, cur_col_r - CW'(1)};
              dirty_nxt   = 1'b1;
            end else if (cur_row_r != '0) begin
              cur_row_nxt = cur_row_r - RW'(1);
              cur_col_nxt = '0;
              dirty_nxt   = 1'b1;
            end
          end else if (byte_r == tgle_pkg::CH_LF) begin
            if (!row_last) begin
              cur_row_nxt = cur_row_r + RW'(1);
              cur_col_nxt = '0;
              dirty_nxt   = 1'b1;
            end
          end else if (printable && !col_last) begin
            we          = 1'b1;
            wdata       = byte_r[CHW-1:0];
            cur_col_nxt = cur_col_r + CW'(1);
            dirty_nxt   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
      dirty_r   <= 1'b0;
      trunc_r   <= 1'b0;
      stop_r    <= 1'b0;
      sweep_r   <= '0;
    end else begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      dirty_r   <= dirty_nxt;
      trunc_r   <= trunc_nxt;
      stop_r    <= stop_nxt;
      sweep_r   <= sweep_nxt;
    end
  end

  // grid storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= tgle_pkg::op_t'(in_op);
      byte_r <= in_data_byte;
      rrow_r <= in_read_row;
      rcol_r <= in_read_col;
    end
    if (cmd.resp) begin
      out_char_r <= ((op_r == tgle_pkg::OP_READ) && rd_ok) ? rdata_r : '0;
      out_row_r  <= cur_row_r;
      out_col_r  <= cur_col_r;
      out_mod_r  <= dirty_r;
      out_cut_r  <= trunc_r;
      out_save_r <= (op_r == tgle_pkg::OP_KEY) && (byte_r == tgle_pkg::KEY_ESC);
    end
  end

  assign out_cell_char    = out_char_r;
  assign out_cur_row      = RPW'(out_row_r);
  assign out_cur_col      = CPW'(out_col_r);
  assign out_modified     = out_mod_r;
  assign out_cut_short    = out_cut_r;
  assign out_save_request = out_save_r;

  `TGLE_ASSERT(a_cursor_range, (int'(cur_col_r) < COLS) && (int'(cur_row_r) < ROWS), "cursor outside grid")
  `TGLE_ASSERT_NEXT(a_clear_home, cmd.clr, (cur_row_r == '0) && (cur_col_r == '0) && !dirty_r && !trunc_r && !stop_r, "clear left state behind")

endmodule

`default_nettype wire

FILE: hw/rtl/tgle_ctrl.sv
// ----------------------------------------------------------------------------
// tgle_ctrl
// Sequencer for clear sweep, item execution, backspace row scan and result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tgle_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire tgle_pkg::status_t sts,
  output tgle_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_CK,
    S_RESP
  } state_t;

  state_t st_r, st_nxt;
  logic   clr_op_r, clr_op_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = st_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    st_nxt        = st_r;
    clr_op_nxt    = clr_op_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (st_r)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          st_nxt     = clr_op_r ? S_RESP : S_IDLE;
          clr_op_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          st_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.op == tgle_pkg::OP_CLEAR) begin
          cmd.clr    = 1'b1;
          clr_op_nxt = 1'b1;
          st_nxt     = S_SWEEP;
        end else begin
          cmd.exec = 1'b1;
          st_nxt   = sts.need_scan ? S_SCAN_RD : S_RESP;
        end
      end
      S_SCAN_RD: begin
        st_nxt = sts.col_last ? S_RESP : S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (sts.cell_zero) begin
          st_nxt = S_RESP;
        end else begin
          cmd.col_inc = 1'b1;
          st_nxt      = S_SCAN_RD;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          cmd.resp      = 1'b1;
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_SWEEP;
      clr_op_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_op_r    <= clr_op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TGLE_ASSERT(a_resp_slot, cmd.resp |-> (!out_valid_r || out_ready), "result overwrote pending transfer")
  `TGLE_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, (st_r == S_EXEC) && !in_ready, "accepted item not executed")
  `TGLE_ASSERT(a_cmd_onehot, $onehot0(cmd), "conflicting datapath commands")

endmodule

`default_nettype wire

FILE: hw/rtl/text_grid_line_editor.sv
// Sequence: a load, key or read item passes the idle, execute and result
// states, and out_valid rises with the registered result; a backspace at
// column 0 adds a read and check loop over the previous row. A clear sweeps
// the grid RAM one cell a cycle over ROWS*2^clog2(COLS) cells (512 at 16x32).
// Flow: one item in flight; the result state waits for a free output slot.
// Reset: synchronous active-low; afterwards the same sweep runs before in_ready.
// ----------------------------------------------------------------------------
// text_grid_line_editor
// Character-cell text buffer with stream loading and key editing.
// ----------------------------------------------------------------------------
`default_nettype none

module text_grid_line_editor #(
  parameter int ROWS = tgle_pkg::ROWS_DEF,
  parameter int COLS = tgle_pkg::COLS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_op,
  input  wire logic [7:0]                      in_data_byte,
  input  wire logic [tgle_pkg::ROW_PORT_W-1:0] in_read_row,
  input  wire logic [tgle_pkg::COL_PORT_W-1:0] in_read_col,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [tgle_pkg::CHAR_W-1:0]          out_cell_char,
  output logic [tgle_pkg::ROW_PORT_W-1:0]      out_cur_row,
  output logic [tgle_pkg::COL_PORT_W-1:0]      out_cur_col,
  output logic                                 out_modified,
  output logic                                 out_cut_short,
  output logic                                 out_save_request
);

  tgle_pkg::cmd_t    cmd;
  tgle_pkg::status_t sts;

  tgle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tgle_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_op),
    .in_data_byte     (in_data_byte),
    .in_read_row      (in_read_row),
    .in_read_col      (in_read_col),
    .out_cell_char    (out_cell_char),
    .out_cur_row      (out_cur_row),
    .out_cur_col      (out_cur_col),
    .out_modified     (out_modified),
    .out_cut_short    (out_cut_short),
    .out_save_request (out_save_request)
  );

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_grid_line_editor. A shadow copy of the grid,
// cursor and flags predicts the one result of each accepted transfer. Directed
// corner items run first. Random bursts of clears, stream loads, key edits
// and reads follow, under four idle and stall phases on the two channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int ROWS        = tgle_pkg::ROWS_DEF;
  localparam int COLS        = tgle_pkg::COLS_DEF;
  localparam int CHW         = tgle_pkg::CHAR_W;
  localparam int RPW         = tgle_pkg::ROW_PORT_W;
  localparam int CPW         = tgle_pkg::COL_PORT_W;
  localparam int TOTAL_ITEMS = 800;
  localparam int PHASE_LEN   = 200;
  localparam int SETTLE      = 2 * COLS + 16;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [CHW-1:0] cell_char;
    logic [RPW-1:0] cur_row;
    logic [CPW-1:0] cur_col;
    logic           modified;
    logic           cut_short;
    logic           save_request;
  } editor_result_t;

  class editor_shadow;
    logic [CHW-1:0] cells [ROWS][COLS];
    int unsigned    row;
    int unsigned    col;
    bit             dirty;
    bit             trunc;
    bit             stopped;
    editor_result_t expected_q[$];
    int unsigned    mismatches;

    function new();
      mismatches = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (cells[r, c]) cells[r][c] = '0;
      row     = 0;
      col     = 0;
      dirty   = 0;
      trunc   = 0;
      stopped = 0;
    endfunction

    function bit printable(logic [7:0] b);
      return b >= tgle_pkg::PRINT_LO && b < tgle_pkg::PRINT_HI;
    endfunction

    function void load_byte(logic [7:0] b);
      if (stopped || b == tgle_pkg::CH_CR) return;
      if (b == tgle_pkg::CH_LF) begin
        if (row + 1 >= ROWS) begin
          trunc   = 1;
          stopped = 1;
        end else begin
          row++;
          col = 0;
        end
        return;
      end
      if (!printable(b)) return;
      if (col >= COLS - 1) begin
        trunc = 1;
        return;
      end
      cells[row][col] = b[CHW-1:0];
      col++;
    endfunction

    function void key_press(logic [7:0] b);
      if (b == tgle_pkg::KEY_BS) begin
        if (col > 0) begin
          col--;
          cells[row][col] = '0;
          dirty = 1;
        end else if (row > 0) begin
          row--;
          col = 0;
          while (col < COLS - 1 && cells[row][col] != '0) col++;
          dirty = 1;
        end
      end else if (b == tgle_pkg::CH_LF) begin
        if (row + 1 < ROWS) begin
          row++;
          col   = 0;
          dirty = 1;
        end
      end else if (printable(b)) begin
        if (col < COLS - 1) begin
          cells[row][col] = b[CHW-1:0];
          col++;
          dirty = 1;
        end
      end
    endfunction

    function void note_item(tgle_pkg::op_t op, logic [7:0] b, logic [RPW-1:0] rr,
                            logic [CPW-1:0] rc);
      editor_result_t exp;
      exp = '0;
      case (op)
        tgle_pkg::OP_CLEAR: wipe();
        tgle_pkg::OP_LOAD:  load_byte(b);
        tgle_pkg::OP_KEY: begin
          if (b == tgle_pkg::KEY_ESC) exp.save_request = 1'b1;
          else key_press(b);
        end
        default: begin
          if (rr < ROWS && rc < COLS) exp.cell_char = cells[rr][rc];
        end
      endcase
      exp.cur_row   = row[RPW-1:0];
      exp.cur_col   = col[CPW-1:0];
      exp.modified  = dirty;
      exp.cut_short = trunc;
      expected_q.push_back(exp);
    endfunction

    function string show(editor_result_t r);
      return $sformatf("cell=%0d row=%0d col=%0d mod=%b cut=%b save=%b",
                       r.cell_char, r.cur_row, r.cur_col, r.modified, r.cut_short,
                       r.save_request);
    endfunction

    function void check_result(editor_result_t got);
      editor_result_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("unexpected transfer: %s", show(got));
        return;
      end
      exp = expected_q.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("bad transfer: expected %s, actual %s", show(exp), show(got));
      end
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  logic [1:0]     in_op;
  logic [7:0]     in_data_byte;
  logic [RPW-1:0] in_read_row;
  logic [CPW-1:0] in_read_col;
  logic           out_valid;
  logic           out_ready;
  logic [CHW-1:0] out_cell_char;
  logic [RPW-1:0] out_cur_row;
  logic [CPW-1:0] out_cur_col;
  logic           out_modified;
  logic           out_cut_short;
  logic           out_save_request;

  editor_shadow shadow;
  int unsigned  items_sent     = 0;
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  cycle_count    = 0;

  text_grid_line_editor dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_data_byte     (in_data_byte),
    .in_read_row      (in_read_row),
    .in_read_col      (in_read_col),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_char    (out_cell_char),
    .out_cur_row      (out_cur_row),
    .out_cur_col      (out_cur_col),
    .out_modified     (out_modified),
    .out_cut_short    (out_cut_short),
    .out_save_request (out_save_request)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_grid_line_editor: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // note the input before the result check: same-edge order is irrelevant here
  always @(posedge clk) begin
    editor_result_t got;
    if (rst_n && in_valid && in_ready)
      shadow.note_item(tgle_pkg::op_t'(in_op), in_data_byte, in_read_row, in_read_col);
    if (rst_n && out_valid && out_ready) begin
      got = {out_cell_char, out_cur_row, out_cur_col, out_modified, out_cut_short,
             out_save_request};
      shadow.check_result(got);
    end
  end

  task automatic send_item(tgle_pkg::op_t op, logic [7:0] b, logic [RPW-1:0] rr,
                           logic [CPW-1:0] rc);
    case (items_sent / PHASE_LEN)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 66;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 66;
      end
      default: begin
        send_idle_pct  = 23;
        recv_stall_pct = 23;
      end
    endcase
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_data_byte <= b;
    in_read_row  <= rr;
    in_read_col  <= rc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  initial begin
    int unsigned n;
    int unsigned pick;
    int unsigned kind;
    logic [7:0]  b;

    shadow       = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_op        = tgle_pkg::OP_CLEAR;
    in_data_byte = '0;
    in_read_row  = '0;
    in_read_col  = '0;
    out_ready    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // corner items; the first loads run without a prior clear
    send_item(tgle_pkg::OP_READ,  8'($urandom), 4'd0, 5'd0);
    send_item(tgle_pkg::OP_LOAD,  "H", 4'($urandom), 5'($urandom));
    send_item(tgle_pkg::OP_LOAD,  tgle_pkg::CH_CR, 4'($urandom), 5'($urandom));
    send_item(tgle_pkg::OP_LOAD,  8'd0, 4'($urandom), 5'($urandom));
    send_item(tgle_pkg::OP_LOAD,  8'd255, 4'($urandom), 5'($urandom));
    send_item(tgle_pkg::OP_LOAD,  tgle_pkg::PRINT_HI, 4'($urandom), 5'($urandom));
    send_item(tgle_pkg::OP_LOAD,  8'd126, 4'($urandom), 5'($urandom));
    send_item(tgle_pkg::OP_LOAD,  tgle_pkg::CH_LF, 4'($urandom), 5'($urandom));
    send_item(tgle_pkg::OP_LOAD,  tgle_pkg::PRINT_LO, 4'($urandom), 5'($urandom));
    send_item(tgle_pkg::OP_KEY,   tgle_pkg::KEY_ESC, 4'($urandom), 5'($urandom));
    send_item(tgle_pkg::OP_KEY,   tgle_pkg::KEY_BS, 4'($urandom), 5'($urandom));
    send_item(tgle_pkg::OP_KEY,   tgle_pkg::KEY_BS, 4'($urandom), 5'($urandom));
    send_item(tgle_pkg::OP_KEY,   8'd200, 4'($urandom), 5'($urandom));
    send_item(tgle_pkg::OP_KEY,   tgle_pkg::PRINT_HI, 4'($urandom), 5'($urandom));
    send_item(tgle_pkg::OP_KEY,   tgle_pkg::CH_LF, 4'($urandom), 5'($urandom));
    send_item(tgle_pkg::OP_KEY,   "z", 4'($urandom), 5'($urandom));
    send_item(tgle_pkg::OP_READ,  8'($urandom), 4'd15, 5'd31);
    send_item(tgle_pkg::OP_READ,  8'($urandom), 4'd0, 5'd1);
    send_item(tgle_pkg::OP_READ,  8'($urandom), 4'd1, 5'd0);
    send_item(tgle_pkg::OP_CLEAR, 8'($urandom), 4'($urandom), 5'($urandom));
    send_item(tgle_pkg::OP_KEY,   tgle_pkg::KEY_BS, 4'($urandom), 5'($urandom));
    send_item(tgle_pkg::OP_READ,  8'($urandom), 4'd0, 5'd0);

    while (items_sent < TOTAL_ITEMS) begin
      kind = $urandom_range(9);
      case (kind)
        0: send_item(tgle_pkg::OP_CLEAR, 8'($urandom), 4'($urandom), 5'($urandom));
        1, 2: begin
          n = $urandom_range(8, 40);
          repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 55) b = 8'($urandom_range(32, 126));
            else if (pick < 70) b = tgle_pkg::CH_LF;
            else if (pick < 77) b = tgle_pkg::CH_CR;
            else b = 8'($urandom);
            send_item(tgle_pkg::OP_LOAD, b, 4'($urandom), 5'($urandom));
          end
        end
        3: begin
          n = $urandom_range(28, 40);
          repeat (n) send_item(tgle_pkg::OP_LOAD, 8'($urandom_range(32, 126)),
                               4'($urandom), 5'($urandom));
          send_item(tgle_pkg::OP_LOAD, tgle_pkg::CH_LF, 4'($urandom), 5'($urandom));
        end
        4: begin
          n = $urandom_range(8, 20);
          repeat (n) send_item($urandom_range(1) ? tgle_pkg::OP_LOAD : tgle_pkg::OP_KEY,
                               tgle_pkg::CH_LF, 4'($urandom), 5'($urandom));
        end
        5, 6: begin
          n = $urandom_range(8, 30);
          repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 40) b = 8'($urandom_range(32, 126));
            else if (pick < 60) b = tgle_pkg::KEY_BS;
            else if (pick < 72) b = tgle_pkg::CH_LF;
            else if (pick < 78) b = tgle_pkg::KEY_ESC;
            else b = 8'($urandom);
            send_item(tgle_pkg::OP_KEY, b, 4'($urandom), 5'($urandom));
          end
        end
        7: begin
          n = $urandom_range(5, 40);
          repeat (n) send_item(tgle_pkg::OP_KEY, tgle_pkg::KEY_BS, 4'($urandom),
                               5'($urandom));
        end
        8: begin
          n = $urandom_range(4, 16);
          repeat (n) send_item(tgle_pkg::OP_READ, 8'($urandom),
                               $urandom_range(1) ? 4'($urandom) : 4'($urandom_range(3)),
                               5'($urandom));
        end
        default: begin
          n = $urandom_range(3, 8);
          repeat (n) send_item(tgle_pkg::op_t'($urandom_range(3)), 8'($urandom),
                               4'($urandom), 5'($urandom));
        end
      endcase
    end
    in_valid <= 1'b0;

    while (shadow.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.expected_q.size() == 0) begin
      $display("text_grid_line_editor: match");
    end else begin
      $display("text_grid_line_editor: mismatch");
    end
    $finish;
  end

endmodule
